### src/trq_pkg.sv
// Shared types and constants of the time-ordered retransmit queue.
// Used by trq_cell and time_ordered_retransmit_queue; depends on nothing.
`default_nettype none

package trq_pkg;

   localparam int DEPTH      = 16;
   localparam int TIME_BITS  = 32;
   localparam int TAG_BITS   = 16;
   localparam int RETRY_BITS = 8;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   localparam int ENTRY_BITS    = TIME_BITS + TAG_BITS + RETRY_BITS;
   localparam int REQ_DATA_BITS = ((ENTRY_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = ENTRY_BITS + COUNT_BITS + 2;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef enum logic [1:0] {
      KIND_INSERT      = 2'd0,
      KIND_REMOVE_HEAD = 2'd1,
      KIND_REMOVE_TAG  = 2'd2,
      KIND_PEEK        = 2'd3
   } kind_type;

   typedef struct packed {
      logic [RETRY_BITS-1:0] retries;
      logic [TAG_BITS-1:0]   tag;
      logic [TIME_BITS-1:0]  due;
   } entry_type;

   // broadcast to every cell for one request
   typedef struct packed {
      logic      insert;
      logic      remove;
      logic      head_mode;
      entry_type key;
   } op_type;

   // per-cell position relative to the fill level
   typedef struct packed {
      logic occupied;
      logic at_fill;
   } slot_ctrl_type;

endpackage

`default_nettype wire

### src/trq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// Depends on trq_pkg.
`default_nettype none

module trq_cell (
   input  wire                     clock,
   input  trq_pkg::op_type         op,
   input  trq_pkg::slot_ctrl_type  slot,
   input  wire                     left_later,
   input  wire                     left_seen,
   input  trq_pkg::entry_type      left_entry,
   input  trq_pkg::entry_type      right_entry,
   output trq_pkg::entry_type      entry_q,
   output trq_pkg::entry_type      entry_next,
   output logic                    later,
   output logic                    seen
);

   trq_pkg::entry_type entry_ff;
   trq_pkg::entry_type entry_in;
   logic               match;

   always_comb begin
      // key goes before this slot
      later = slot.occupied && (op.key.due < entry_ff.due);
      match = slot.occupied && (op.head_mode || (entry_ff.tag == op.key.tag));
      seen  = left_seen || match;

      priority if (op.insert) begin
         if (left_later) begin
            entry_in = left_entry;
         end else if (later || slot.at_fill) begin
            entry_in = op.key;
         end else begin
            entry_in = entry_ff;
         end
      end else if (op.remove && seen) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q    = entry_ff;
   assign entry_next = entry_in;

endmodule

`default_nettype wire

### src/time_ordered_retransmit_queue.sv
// Top level of the time-ordered retransmit queue: fill count, request decode,
// the chain of trq_cell slots and the response register. Depends on trq_pkg, trq_cell.
//
// For each request (insert, remove head, remove by tag, peek),
// the cell chain compares, shifts and re-sorts all slots in the cycle the
// request is accepted, and the response, describing the head after the
// operation, appears in the output register on the next cycle. A new
// request is taken every cycle while the response is consumed or the
// register is empty. The tag search ripples a found flag along the chain,
// which sets the longest path. Slots carry no reset; the fill count marks
// which ones hold entries.
`default_nettype none

module time_ordered_retransmit_queue (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [31:0] due_time, [47:32] packet_tag, [55:48] retry_count
   input  wire  [trq_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // [1:0] kind
   input  wire  [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [31:0] head_time, [47:32] head_tag, [55:48] head_retries,
   // [60:56] entry_count, [61] insert_refused, [62] tag_missing, rest zero
   output logic [trq_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // [0] head_valid
   output logic [0:0]  rsp_tuser
);

   localparam int D = trq_pkg::DEPTH;
   localparam int CB = trq_pkg::COUNT_BITS;

   logic [CB-1:0]          fill_ff, fill_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [trq_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                   head_valid_ff, head_valid_in;

   logic                   accept;
   trq_pkg::kind_type      kind;
   logic                   full;
   logic                   found;
   logic                   refused;
   logic                   missing;
   trq_pkg::op_type        op;
   trq_pkg::entry_type     head;
   trq_pkg::slot_ctrl_type slot [D];
   trq_pkg::entry_type     entry_q [D];
   trq_pkg::entry_type     entry_next [D];
   logic [D-1:0]           later;
   logic [D-1:0]           seen;

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      kind = trq_pkg::kind_type'(req_tuser);
      full = (fill_ff == CB'(D));

      op.key.due     = req_tdata[trq_pkg::TIME_BITS-1:0];
      op.key.tag     = req_tdata[trq_pkg::TIME_BITS +: trq_pkg::TAG_BITS];
      op.key.retries = req_tdata[trq_pkg::TIME_BITS + trq_pkg::TAG_BITS +:
                                 trq_pkg::RETRY_BITS];
      op.head_mode   = (kind == trq_pkg::KIND_REMOVE_HEAD);
      op.insert      = accept && (kind == trq_pkg::KIND_INSERT) && !full;
      op.remove      = accept && ((kind == trq_pkg::KIND_REMOVE_HEAD) ||
                                  (kind == trq_pkg::KIND_REMOVE_TAG));

      for (int i = 0; i < D; i++) begin
         slot[i].occupied = (CB'(i) < fill_ff);
         slot[i].at_fill  = (CB'(i) == fill_ff);
      end
   end

   genvar g;
   generate
      for (g = 0; g < D; g++) begin : g_cell
         trq_pkg::entry_type left_entry;
         trq_pkg::entry_type right_entry;
         logic               left_later;
         logic               left_seen;

         if (g == 0) begin : g_first
            assign left_entry = entry_q[0];
            assign left_later = 1'b0;
            assign left_seen  = 1'b0;
         end else begin : g_mid
            assign left_entry = entry_q[g-1];
            assign left_later = later[g-1];
            assign left_seen  = seen[g-1];
         end

         if (g == D - 1) begin : g_last
            assign right_entry = entry_q[g];
         end else begin : g_inner
            assign right_entry = entry_q[g+1];
         end

         trq_cell u_cell (
            .clock       (clock),
            .op          (op),
            .slot        (slot[g]),
            .left_later  (left_later),
            .left_seen   (left_seen),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry_q     (entry_q[g]),
            .entry_next  (entry_next[g]),
            .later       (later[g]),
            .seen        (seen[g])
         );
      end
   endgenerate

   always_comb begin
      found   = seen[D-1];
      refused = (kind == trq_pkg::KIND_INSERT) && full;
      missing = (kind == trq_pkg::KIND_REMOVE_TAG) && !found;

      priority if (op.insert) begin
         fill_in = fill_ff + CB'(1);
      end else if (op.remove && found) begin
         fill_in = fill_ff - CB'(1);
      end else begin
         fill_in = fill_ff;
      end

      head_valid_in = (fill_in != '0);
      head = head_valid_in ? entry_next[0] : '0;

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = trq_pkg::RSP_DATA_BITS'({missing, refused, fill_in, head});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         head_valid_ff <= head_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = head_valid_ff;

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for time_ordered_retransmit_queue: stream requests in,
// head reports out, checked against a sorted mirror of the queue held in a class.
// Depends on trq_pkg and the RTL of the block.

module tb;

   localparam int TAG_LSB     = trq_pkg::TIME_BITS;
   localparam int RETRY_LSB   = trq_pkg::TIME_BITS + trq_pkg::TAG_BITS;
   localparam int COUNT_LSB   = trq_pkg::ENTRY_BITS;
   localparam int REFUSED_BIT = trq_pkg::ENTRY_BITS + trq_pkg::COUNT_BITS;
   localparam int MISSING_BIT = trq_pkg::ENTRY_BITS + trq_pkg::COUNT_BITS + 1;
   localparam int RANDOM_ITEMS = 750;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic                           valid;
      logic [trq_pkg::TIME_BITS-1:0]  due;
      logic [trq_pkg::TAG_BITS-1:0]   tag;
      logic [trq_pkg::RETRY_BITS-1:0] retries;
      logic [trq_pkg::COUNT_BITS-1:0] count;
      logic                           refused;
      logic                           missing;
   } head_report;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   class queue_mirror;
      trq_pkg::entry_type slots[trq_pkg::DEPTH];
      int         fill;
      head_report expected_heads[$];
      int errors, checked, inserts, refusals, tag_hits, misses, peak;

      function void drop_slot(int pos);
         int i;
         for (i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
         fill--;
      endfunction

      // apply one accepted request and queue the head report it must produce
      function void note_request(trq_pkg::kind_type kind, trq_pkg::entry_type item);
         head_report r;
         int pos, i, hit;
         r = '0;
         hit = -1;
         case (kind)
            trq_pkg::KIND_INSERT: begin
               inserts++;
               if (fill >= trq_pkg::DEPTH) begin
                  r.refused = 1'b1;
                  refusals++;
               end else begin
                  pos = 0;
                  while (pos < fill && !(item.due < slots[pos].due)) pos++;
                  for (i = fill; i > pos; i--) slots[i] = slots[i - 1];
                  slots[pos] = item;
                  fill++;
               end
            end
            trq_pkg::KIND_REMOVE_HEAD: begin
               if (fill > 0) drop_slot(0);
            end
            trq_pkg::KIND_REMOVE_TAG: begin
               for (i = 0; i < fill; i++)
                  if (hit < 0 && slots[i].tag == item.tag) hit = i;
               if (hit < 0) begin
                  r.missing = 1'b1;
                  misses++;
               end else begin
                  drop_slot(hit);
                  tag_hits++;
               end
            end
            default: ;
         endcase
         if (fill > peak) peak = fill;
         if (fill > 0) begin
            r.valid   = 1'b1;
            r.due     = slots[0].due;
            r.tag     = slots[0].tag;
            r.retries = slots[0].retries;
         end
         r.count = trq_pkg::COUNT_BITS'(fill);
         expected_heads.push_back(r);
      endfunction

      task report(string field, logic [63:0] got, logic [63:0] want);
         errors++;
         if (errors <= 30)
            $display("mismatch %s: got %h want %h (response %0d)", field, got, want, checked);
      endtask

      task check_response(logic [trq_pkg::RSP_DATA_BITS-1:0] data, logic valid);
         head_report w;
         if (expected_heads.size() == 0) begin
            report("unexpected response", 64'(data), 64'd0);
            return;
         end
         w = expected_heads.pop_front();
         if (valid !== w.valid) report("head_valid", 64'(valid), 64'(w.valid));
         if (data[trq_pkg::TIME_BITS-1:0] !== w.due)
            report("head_time", 64'(data[trq_pkg::TIME_BITS-1:0]), 64'(w.due));
         if (data[TAG_LSB +: trq_pkg::TAG_BITS] !== w.tag)
            report("head_tag", 64'(data[TAG_LSB +: trq_pkg::TAG_BITS]), 64'(w.tag));
         if (data[RETRY_LSB +: trq_pkg::RETRY_BITS] !== w.retries)
            report("head_retries", 64'(data[RETRY_LSB +: trq_pkg::RETRY_BITS]),
                   64'(w.retries));
         if (data[COUNT_LSB +: trq_pkg::COUNT_BITS] !== w.count)
            report("entry_count", 64'(data[COUNT_LSB +: trq_pkg::COUNT_BITS]),
                   64'(w.count));
         if (data[REFUSED_BIT] !== w.refused)
            report("insert_refused", 64'(data[REFUSED_BIT]), 64'(w.refused));
         if (data[MISSING_BIT] !== w.missing)
            report("tag_missing", 64'(data[MISSING_BIT]), 64'(w.missing));
         checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [trq_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [1:0] req_tuser = trq_pkg::KIND_PEEK;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [trq_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   queue_mirror mirror = new;
   int  gap_pct = 0;
   int  stall_pct = 0;
   bit  calm = 1'b0;
   int  stall_left = 0;
   int  cycles = 0;
   int  sent = 0;

   time_ordered_retransmit_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending",
                  cycles, mirror.expected_heads.size());
         $display("FAIL time_ordered_retransmit_queue");
         $finish;
      end
   end

   // response side: random stall bursts on rsp_tready
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         mirror.check_response(rsp_tdata, rsp_tuser[0]);
   end

   task automatic send_request(trq_pkg::kind_type kind,
                               logic [trq_pkg::TIME_BITS-1:0] due,
                               logic [trq_pkg::TAG_BITS-1:0] tag,
                               logic [trq_pkg::RETRY_BITS-1:0] retries);
      trq_pkg::entry_type e;
      e.due     = due;
      e.tag     = tag;
      e.retries = retries;
      req_tvalid <= 1'b1;
      req_tdata  <= e;
      req_tuser  <= kind;
      do @(posedge clock); while (req_tready !== 1'b1);
      mirror.note_request(kind, e);
      sent++;
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= trq_pkg::REQ_DATA_BITS'({$urandom, $urandom});
         req_tuser  <= 2'($urandom);
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   initial begin
      mix_type mix;
      trq_pkg::kind_type kind;
      logic [trq_pkg::TIME_BITS-1:0] base, due;
      logic [trq_pkg::TAG_BITS-1:0] tag;
      int phase_len, ins_pct, pick;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty queue, extremes, stable order on equal times, duplicate tags
      send_request(trq_pkg::KIND_PEEK, '0, '0, '0);
      send_request(trq_pkg::KIND_REMOVE_HEAD, '1, '1, '1);
      send_request(trq_pkg::KIND_REMOVE_TAG, '0, '1, '0);
      send_request(trq_pkg::KIND_INSERT, '1, '1, '1);
      send_request(trq_pkg::KIND_INSERT, '0, '0, '0);
      send_request(trq_pkg::KIND_INSERT, 32'd100, 16'd5, 8'd1);
      send_request(trq_pkg::KIND_INSERT, 32'd100, 16'd6, 8'd2);
      send_request(trq_pkg::KIND_INSERT, 32'd100, 16'd5, 8'd3);
      send_request(trq_pkg::KIND_PEEK, '1, '1, '1);
      send_request(trq_pkg::KIND_REMOVE_TAG, '0, 16'd5, '0);
      send_request(trq_pkg::KIND_REMOVE_TAG, '0, 16'd1234, '0);
      send_request(trq_pkg::KIND_REMOVE_HEAD, '0, '0, '0);
      send_request(trq_pkg::KIND_REMOVE_TAG, '0, '1, '0);
      send_request(trq_pkg::KIND_REMOVE_TAG, '0, 16'd6, '0);
      send_request(trq_pkg::KIND_REMOVE_TAG, '0, 16'd5, '0);
      send_request(trq_pkg::KIND_REMOVE_HEAD, '0, '0, '0);
      send_request(trq_pkg::KIND_PEEK, '0, '0, '0);

      sent = 0;
      mix = MIX_FILL;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(30, 70);
         base = $urandom;
         case ($urandom_range(0, 2))
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 20; stall_pct = 20; end
            default: begin gap_pct = 50; stall_pct = 50; end
         endcase
         ins_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 20 : 45;
         repeat (phase_len) begin
            calm = (sent >= RANDOM_ITEMS - 100);
            pick = $urandom_range(0, 99);
            if (pick < ins_pct) kind = trq_pkg::KIND_INSERT;
            else if (pick < ins_pct + (100 - ins_pct) * 35 / 100)
               kind = trq_pkg::KIND_REMOVE_HEAD;
            else if (pick < ins_pct + (100 - ins_pct) * 80 / 100)
               kind = trq_pkg::KIND_REMOVE_TAG;
            else kind = trq_pkg::KIND_PEEK;

            case ($urandom_range(0, 9))
               0: due = $urandom;
               1: due = $urandom_range(0, 1) ? '1 : '0;
               default: due = base + $urandom_range(0, 15);
            endcase
            // small tag pool gives duplicates and hits; sometimes a tag held now
            if (kind == trq_pkg::KIND_REMOVE_TAG && mirror.fill > 0 &&
                $urandom_range(0, 99) < 60)
               tag = mirror.slots[$urandom_range(0, mirror.fill - 1)].tag;
            else if ($urandom_range(0, 3) == 0)
               tag = trq_pkg::TAG_BITS'($urandom);
            else
               tag = trq_pkg::TAG_BITS'($urandom_range(0, 7));
            send_request(kind, due, tag, trq_pkg::RETRY_BITS'($urandom_range(0, 255)));
         end
         case ($urandom_range(0, 2))
            0: mix = MIX_FILL;
            1: mix = MIX_DRAIN;
            default: mix = MIX_EVEN;
         endcase
      end
      req_tvalid <= 1'b0;

      while (mirror.expected_heads.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d responses checked: %0d inserts (%0d refused when full), peak fill %0d",
               mirror.checked, mirror.inserts, mirror.refusals, mirror.peak);
      $display("tag removals: %0d found, %0d missing; %0d mismatches",
               mirror.tag_hits, mirror.misses, mirror.errors);
      if (mirror.errors == 0)
         $display("PASS time_ordered_retransmit_queue");
      else
         $display("FAIL time_ordered_retransmit_queue");
      $finish;
   end

endmodule
